// ===== hdl/lruc_pkg.sv =====
// shared types and constants for the lru unit assignment cache
// no dependencies
`default_nettype none

package lruc_pkg;

	localparam int OBJ_KEY_W    = 32;
	localparam int UNIT_W       = 5;
	localparam int IN_W         = 32;
	localparam int OUT_W        = 40;
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int ACTIVE_W     = 6;
	localparam int ACTIVE_RST   = 32;
	localparam int UNITS_DEF    = 32;
	localparam int KEY_BITS_DEF = 32;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// register index as seen in paddr bit 2
	localparam logic REG_ACTIVE_UNITS = 1'b0;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_AGE,
		MODE_DROP
	} rank_mode_t;

	typedef struct packed {
		rank_mode_t mode;
		logic       wr;
		logic       clr;
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} fsm_state_t;

endpackage

`default_nettype wire

// ===== hdl/lru_unit_assignment_cache.sv =====
// Fully associative LRU cache mapping object keys to binding units. In the
// accept cycle of an input word every cell compares the key and the
// free-slot ripple and rank search settle into registers; in the update
// cycle the row of cells applies the rank change and the result word is
// loaded into the output register. A result word that is still held
// stretches the update cycle until the output register frees.
// top level; uses lruc_pkg, lruc_cell and lruc_victim
`default_nettype none

module lru_unit_assignment_cache #(
	parameter int UNITS    = lruc_pkg::UNITS_DEF,
	parameter int KEY_BITS = lruc_pkg::KEY_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [lruc_pkg::IN_W-1:0]       s_tdata,  // object_key
	input  wire logic                            s_tuser,  // operation
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// unit[4:0], hit[5], bind_needed[6], evicted[7], evicted_key[39:8]
	output logic [lruc_pkg::OUT_W-1:0]           m_tdata,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lruc_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [lruc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [lruc_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                 pready
);
	import lruc_pkg::*;

	localparam int RW = $clog2(UNITS);
	localparam int AW = $clog2(UNITS + 1);

	fsm_state_t state_q, state_nx;

	logic [ACTIVE_W-1:0] active_q;
	logic [AW-1:0]       act_eff;

	logic [KEY_BITS-1:0]           key_in;
	logic [UNITS-1:0]              match_v, cand_v, ffree_v, vic_oh;
	logic [UNITS:0]                free_chain;
	logic [UNITS-1:0][KEY_BITS-1:0] keys;
	logic [UNITS-1:0][RW-1:0]      ranks;
	logic [RW-1:0]                 vic_rank;
	logic [RW-1:0]                 match_idx, free_idx, vic_idx, match_rank;

	logic                op_q, hit_q, free_any_q;
	logic [KEY_BITS-1:0] key_q;
	logic [RW-1:0]       match_idx_q, free_idx_q, vic_idx_q, match_rank_q, vic_rank_q;
	logic [UNITS-1:0]    vic_oh_q;

	logic                accept, fire;
	cell_cmd_t           cmd;
	logic [RW-1:0]       tgt;
	logic [RW:0]         thr;
	logic [KEY_BITS-1:0] vic_key;
	logic [RW-1:0]       unit_idx;
	logic                bind_o, ev_o;

	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_W'(ACTIVE_RST);
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE_UNITS) begin
			active_q <= pwdata[ACTIVE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ACTIVE_UNITS)
			prdata = CFG_DATA_W'(active_q);
	end

	always_comb begin
		if (active_q == '0)
			act_eff = AW'(1);
		else if (32'(active_q) > 32'(UNITS))
			act_eff = AW'(UNITS);
		else
			act_eff = AW'(active_q);
	end

	// cell row
	assign key_in        = KEY_BITS'(s_tdata);
	assign free_chain[0] = 1'b0;

	for (genvar g = 0; g < UNITS; g++) begin : g_cell
		lruc_cell #(
			.UNITS   (UNITS),
			.KEY_BITS(KEY_BITS),
			.IDX     (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.tgt       (tgt),
			.thr       (thr),
			.wkey      (key_q),
			.lkey      (key_in),
			.act       (act_eff),
			.free_in   (free_chain[g]),
			.free_out  (free_chain[g+1]),
			.first_free(ffree_v[g]),
			.match     (match_v[g]),
			.cand      (cand_v[g]),
			.key       (keys[g]),
			.rank      (ranks[g])
		);
	end

	lruc_victim #(.UNITS(UNITS)) u_victim (
		.cand    (cand_v),
		.ranks   (ranks),
		.vic_oh  (vic_oh),
		.vic_rank(vic_rank)
	);

	always_comb begin
		match_idx  = '0;
		free_idx   = '0;
		vic_idx    = '0;
		match_rank = '0;
		vic_key    = '0;
		for (int i = 0; i < UNITS; i++) begin
			if (match_v[i]) begin
				match_idx  = match_idx | RW'(i);
				match_rank = match_rank | ranks[i];
			end
			if (ffree_v[i])
				free_idx = free_idx | RW'(i);
			if (vic_oh[i])
				vic_idx = vic_idx | RW'(i);
			if (vic_oh_q[i])
				vic_key = vic_key | keys[i];
		end
	end

	// control
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign fire     = (state_q == ST_UPDATE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_nx = ST_UPDATE;
			ST_UPDATE: if (fire) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= s_tuser;
			key_q        <= key_in;
			hit_q        <= |match_v;
			free_any_q   <= free_chain[UNITS];
			match_idx_q  <= match_idx;
			match_rank_q <= match_rank;
			free_idx_q   <= free_idx;
			vic_idx_q    <= vic_idx;
			vic_rank_q   <= vic_rank;
			vic_oh_q     <= vic_oh;
		end
	end

	// update command for the row
	always_comb begin
		cmd      = '{mode: MODE_NONE, wr: 1'b0, clr: 1'b0};
		tgt      = match_idx_q;
		thr      = {1'b0, match_rank_q};
		unit_idx = '0;
		bind_o   = 1'b0;
		ev_o     = 1'b0;
		if (op_q == OP_REMOVE) begin
			if (hit_q) begin
				cmd      = '{mode: MODE_DROP, wr: 1'b0, clr: 1'b1};
				unit_idx = match_idx_q;
			end
		end else if (hit_q) begin
			cmd      = '{mode: MODE_AGE, wr: 1'b1, clr: 1'b0};
			unit_idx = match_idx_q;
		end else if (free_any_q) begin
			cmd      = '{mode: MODE_AGE, wr: 1'b1, clr: 1'b0};
			tgt      = free_idx_q;
			thr      = (RW + 1)'(UNITS);
			unit_idx = free_idx_q;
			bind_o   = 1'b1;
		end else begin
			cmd      = '{mode: MODE_AGE, wr: 1'b1, clr: 1'b0};
			tgt      = vic_idx_q;
			thr      = {1'b0, vic_rank_q};
			unit_idx = vic_idx_q;
			bind_o   = 1'b1;
			ev_o     = 1'b1;
		end
		if (!fire)
			cmd = '{mode: MODE_NONE, wr: 1'b0, clr: 1'b0};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= {(ev_o ? OBJ_KEY_W'(vic_key) : OBJ_KEY_W'(0)),
				ev_o, bind_o, hit_q, UNIT_W'(unit_idx)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_v))
		else $error("key held in more than one entry");

	a_fire_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("result word not loaded after update");

	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_UPDATE))
		else $error("accepted word not followed by update");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[5] && m_tdata[6]) && (!m_tdata[7] || m_tdata[6]))
		else $error("inconsistent result flags");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ev_o |-> $onehot(vic_oh_q))
		else $error("eviction without a single victim");

endmodule

`default_nettype wire

// ===== hdl/lruc_cell.sv =====
// one cache entry: valid flag, key and recency rank, with key compare
// uses lruc_pkg; chained to its neighbors by the free-slot ripple
`default_nettype none

module lruc_cell #(
	parameter int UNITS    = 32,
	parameter int KEY_BITS = 32,
	parameter int IDX      = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lruc_pkg::cell_cmd_t        cmd,
	input  wire logic [$clog2(UNITS)-1:0]   tgt,
	input  wire logic [$clog2(UNITS):0]     thr,
	input  wire logic [KEY_BITS-1:0]        wkey,
	input  wire logic [KEY_BITS-1:0]        lkey,
	input  wire logic [$clog2(UNITS+1)-1:0] act,
	input  wire logic                       free_in,
	output logic                            free_out,
	output logic                            first_free,
	output logic                            match,
	output logic                            cand,
	output logic [KEY_BITS-1:0]             key,
	output logic [$clog2(UNITS)-1:0]        rank
);
	import lruc_pkg::*;

	localparam int RW = $clog2(UNITS);

	logic                valid_q;
	logic [KEY_BITS-1:0] key_q;
	logic [RW-1:0]       rank_q;
	logic                sel;
	logic                active;
	logic                free;

	assign sel    = (tgt == RW'(IDX));
	assign active = (IDX < int'(act));
	assign free   = !valid_q && active;

	assign free_out   = free_in | free;
	assign first_free = free & !free_in;
	assign match      = valid_q && (key_q == lkey);
	assign cand       = valid_q && active;
	assign key        = key_q;
	assign rank       = rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel && cmd.wr) begin
			valid_q <= 1'b1;
		end else if (sel && cmd.clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.wr) begin
			key_q  <= wkey;
			rank_q <= '0;
		end else if (valid_q) begin
			case (cmd.mode)
				MODE_AGE: begin
					if ({1'b0, rank_q} < thr)
						rank_q <= rank_q + 1'b1;
				end
				MODE_DROP: begin
					if ({1'b0, rank_q} > thr)
						rank_q <= rank_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lruc_victim.sv =====
// least recent entry search: msb-first narrowing over the candidate ranks
// uses lruc_pkg
`default_nettype none

module lruc_victim #(
	parameter int UNITS = 32
) (
	input  wire logic [UNITS-1:0]                    cand,
	input  wire logic [UNITS-1:0][$clog2(UNITS)-1:0] ranks,
	output logic [UNITS-1:0]                         vic_oh,
	output logic [$clog2(UNITS)-1:0]                 vic_rank
);
	import lruc_pkg::*;

	localparam int RW = $clog2(UNITS);

	always_comb begin
		logic [UNITS-1:0] set;
		logic [UNITS-1:0] hi;
		set      = cand;
		vic_rank = '0;
		for (int b = RW - 1; b >= 0; b--) begin
			for (int i = 0; i < UNITS; i++)
				hi[i] = set[i] & ranks[i][b];
			if (|hi) begin
				set         = hi;
				vic_rank[b] = 1'b1;
			end
		end
		vic_oh = set;
	end

endmodule

`default_nettype wire
